// ===== rtl/sdfp_pkg.sv =====
// shared types and constants of the station directory frame parser
`default_nettype none

package sdfp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned KIND_W  = 4;
	localparam int unsigned ACCUM_W = 24;

	localparam logic [KIND_W-1:0] K_TYPE       = 4'd0;
	localparam logic [KIND_W-1:0] K_SNAME_LEN  = 4'd1;
	localparam logic [KIND_W-1:0] K_SNAME_BYTE = 4'd2;
	localparam logic [KIND_W-1:0] K_DESC_LEN   = 4'd3;
	localparam logic [KIND_W-1:0] K_DESC_BYTE  = 4'd4;
	localparam logic [KIND_W-1:0] K_COUNT      = 4'd5;
	localparam logic [KIND_W-1:0] K_ST_NUM     = 4'd6;
	localparam logic [KIND_W-1:0] K_ST_LEN     = 4'd7;
	localparam logic [KIND_W-1:0] K_ST_BYTE    = 4'd8;
	localparam logic [KIND_W-1:0] K_MCAST      = 4'd9;
	localparam logic [KIND_W-1:0] K_DPORT      = 4'd10;
	localparam logic [KIND_W-1:0] K_IPORT      = 4'd11;
	localparam logic [KIND_W-1:0] K_RATE       = 4'd12;

	localparam logic [BYTE_W-1:0] WORD_BYTES = 8'd4;
	localparam logic [BYTE_W-1:0] HALF_BYTES = 8'd2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [BYTE_W-1:0]  index;
		logic               done;
	} sdfp_result_t;

endpackage

`default_nettype wire

// ===== rtl/sdfp_front.sv =====
// front end: byte classification, field accumulation and result generation
`default_nettype none

module sdfp_front
	import sdfp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	input  wire logic [BYTE_W-1:0]  in_byte,
	output logic                    res_valid,
	output sdfp_result_t            res
);

	typedef enum logic [3:0] {
		PH_TYPE      = 4'd0,
		PH_SNAME_LEN = 4'd1,
		PH_SNAME     = 4'd2,
		PH_DESC_LEN  = 4'd3,
		PH_DESC      = 4'd4,
		PH_COUNT     = 4'd5,
		PH_ST_NUM    = 4'd6,
		PH_ST_LEN    = 4'd7,
		PH_ST_NAME   = 4'd8,
		PH_MCAST     = 4'd9,
		PH_DPORT     = 4'd10,
		PH_IPORT     = 4'd11,
		PH_RATE      = 4'd12
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [BYTE_W-1:0]   bytes_left_q, bytes_left_n;
	logic [ACCUM_W-1:0]  accum_q, accum_n;
	logic [BYTE_W-1:0]   station_q, station_n;
	logic [BYTE_W-1:0]   total_q, total_n;
	logic [BYTE_W-1:0]   dec;
	logic [BYTE_W-1:0]   station_inc;
	logic [VALUE_W-1:0]  full;
	logic [VALUE_W-1:0]  byte_ext;
	logic                emit;

	assign dec         = bytes_left_q - 8'd1;
	assign station_inc = station_q + 8'd1;
	assign full        = {accum_q, in_byte};
	assign byte_ext    = {{(VALUE_W-BYTE_W){1'b0}}, in_byte};

	always_comb begin
		phase_n      = phase_q;
		bytes_left_n = bytes_left_q;
		accum_n      = accum_q;
		station_n    = station_q;
		total_n      = total_q;
		emit         = 1'b1;
		res.kind     = K_TYPE;
		res.value    = byte_ext;
		res.index    = '0;
		res.done     = 1'b0;
		unique case (phase_q)
			PH_SNAME_LEN: begin
				res.kind     = K_SNAME_LEN;
				bytes_left_n = in_byte;
				phase_n      = (in_byte == 8'd0) ? PH_DESC_LEN : PH_SNAME;
			end
			PH_SNAME: begin
				res.kind     = K_SNAME_BYTE;
				bytes_left_n = dec;
				if (dec == 8'd0) phase_n = PH_DESC_LEN;
			end
			PH_DESC_LEN: begin
				res.kind     = K_DESC_LEN;
				bytes_left_n = in_byte;
				phase_n      = (in_byte == 8'd0) ? PH_COUNT : PH_DESC;
			end
			PH_DESC: begin
				res.kind     = K_DESC_BYTE;
				bytes_left_n = dec;
				if (dec == 8'd0) phase_n = PH_COUNT;
			end
			PH_COUNT: begin
				res.kind  = K_COUNT;
				res.done  = (in_byte == 8'd0);
				total_n   = in_byte;
				station_n = '0;
				phase_n   = (in_byte == 8'd0) ? PH_TYPE : PH_ST_NUM;
			end
			PH_ST_NUM: begin
				res.kind  = K_ST_NUM;
				res.index = station_q;
				phase_n   = PH_ST_LEN;
			end
			PH_ST_LEN: begin
				res.kind  = K_ST_LEN;
				res.index = station_q;
				if (in_byte == 8'd0) begin
					phase_n      = PH_MCAST;
					bytes_left_n = WORD_BYTES;
					accum_n      = '0;
				end else begin
					phase_n      = PH_ST_NAME;
					bytes_left_n = in_byte;
				end
			end
			PH_ST_NAME: begin
				res.kind     = K_ST_BYTE;
				res.index    = station_q;
				bytes_left_n = dec;
				if (dec == 8'd0) begin
					phase_n      = PH_MCAST;
					bytes_left_n = WORD_BYTES;
					accum_n      = '0;
				end
			end
			PH_MCAST, PH_DPORT, PH_IPORT, PH_RATE: begin
				res.index = station_q;
				res.value = full;
				if (bytes_left_q > 8'd1) begin
					emit         = 1'b0;
					accum_n      = {accum_q[ACCUM_W-BYTE_W-1:0], in_byte};
					bytes_left_n = dec;
				end else begin
					accum_n = '0;
					if (phase_q == PH_MCAST) begin
						res.kind     = K_MCAST;
						phase_n      = PH_DPORT;
						bytes_left_n = HALF_BYTES;
					end else if (phase_q == PH_DPORT) begin
						res.kind     = K_DPORT;
						res.value    = {16'd0, full[15:0]};
						phase_n      = PH_IPORT;
						bytes_left_n = HALF_BYTES;
					end else if (phase_q == PH_IPORT) begin
						res.kind     = K_IPORT;
						res.value    = {16'd0, full[15:0]};
						phase_n      = PH_RATE;
						bytes_left_n = WORD_BYTES;
					end else begin
						res.kind     = K_RATE;
						station_n    = station_inc;
						bytes_left_n = '0;
						res.done     = (station_inc == total_q);
						phase_n      = (station_inc == total_q) ? PH_TYPE : PH_ST_NUM;
					end
				end
			end
			default: begin
				res.kind     = K_TYPE;
				bytes_left_n = '0;
				accum_n      = '0;
				station_n    = '0;
				total_n      = '0;
				phase_n      = PH_SNAME_LEN;
			end
		endcase
	end

	assign res_valid = byte_valid && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TYPE;
			bytes_left_q <= '0;
			accum_q      <= '0;
			station_q    <= '0;
			total_q      <= '0;
		end else if (byte_valid) begin
			phase_q      <= phase_n;
			bytes_left_q <= bytes_left_n;
			accum_q      <= accum_n;
			station_q    <= station_n;
			total_q      <= total_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sdfp_queue.sv =====
// short result queue between the front and back ends
`default_nettype none

module sdfp_queue
	import sdfp_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sdfp_result_t  push_data,
	output logic               full,
	input  wire logic          pop,
	output sdfp_result_t       pop_data,
	output logic               empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	sdfp_result_t      entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sdfp_back.sv =====
// back end: output register that drives the result stream
`default_nettype none

module sdfp_back
	import sdfp_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_empty,
	input  wire sdfp_result_t                q_data,
	output logic                             q_pop,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [VALUE_W+BYTE_W-1:0]        m_axis_tdata,
	output logic [KIND_W-1:0]                m_axis_tuser,
	output logic                             m_axis_tlast
);

	sdfp_result_t out_q;
	logic         valid_q;
	logic         load;

	assign load  = !valid_q || m_axis_tready;
	assign q_pop = load && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) out_q <= q_data;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {out_q.index, out_q.value};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.done;

endmodule

`default_nettype wire

// ===== rtl/station_directory_frame_parser.sv =====
// top level of the station directory frame parser
//
// channel   direction  tdata                                   tuser        tlast
// s_axis    in         [7:0] in_byte                           -            -
// m_axis    out        [31:0] field_value, [39:32] station_idx [3:0] kind    message_done
//
// one byte per cycle sustained while the result queue has room; the front end advances its parse state on
// every accepted byte, so a byte may follow in the very next cycle
// a result is registered in a queue entry and then in the back end output register before it reaches m_axis
// s_axis stalls only while the result queue is full; bytes that only feed
// the accumulator need no queue space but are held back with the rest
// asynchronous active-low reset returns the parser to awaiting a type byte
`default_nettype none

module station_directory_frame_parser
	import sdfp_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [BYTE_W-1:0]           s_axis_tdata,   // [7:0] in_byte
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [VALUE_W+BYTE_W-1:0]        m_axis_tdata,   // [31:0] field_value, [39:32] station_index
	output logic [KIND_W-1:0]                m_axis_tuser,   // [3:0] field_kind
	output logic                             m_axis_tlast
);

	logic         q_full, q_empty, q_pop;
	logic         res_valid;
	logic         byte_accept;
	sdfp_result_t res;
	sdfp_result_t q_data;

	assign s_axis_tready = !q_full;
	assign byte_accept   = s_axis_tvalid && s_axis_tready;

	sdfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_accept),
		.in_byte    (s_axis_tdata),
		.res_valid  (res_valid),
		.res        (res)
	);

	sdfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	sdfp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire
